// File: design/mchp_pkg.sv
// ----------------------------------------------------------------------------
// mchp_pkg: shared definitions for the monotone chain hull pass unit
// Command codes and the stack control group passed from the sequencer to
// the top-of-stack cells.
// ----------------------------------------------------------------------------
package mchp_pkg;

  // command field codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // shift controls for the top-of-stack cell chain
  typedef struct packed {
    logic push;  // shift toward the bottom, new entry enters at the top
    logic pop;   // shift toward the top, refill from below
  } stack_ctrl_t;

endpackage

// File: design/mchp_ram.sv
// ----------------------------------------------------------------------------
// mchp_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mchp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mchp_cell.sv
// ----------------------------------------------------------------------------
// mchp_cell: one top-of-stack cell
// Holds one chain point; takes its upper neighbor's point on a push and its
// lower neighbor's point on a pop.
// ----------------------------------------------------------------------------
module mchp_cell #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  mchp_pkg::stack_ctrl_t         ctrl_i,
  input  logic signed [COORD_WIDTH-1:0] up_x_i,
  input  logic signed [COORD_WIDTH-1:0] up_y_i,
  input  logic signed [COORD_WIDTH-1:0] down_x_i,
  input  logic signed [COORD_WIDTH-1:0] down_y_i,
  output logic signed [COORD_WIDTH-1:0] x_o,
  output logic signed [COORD_WIDTH-1:0] y_o
);

  logic signed [COORD_WIDTH-1:0] x_q, x_d;
  logic signed [COORD_WIDTH-1:0] y_q, y_d;

  // neighbor select
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (ctrl_i.push) begin
      x_d = up_x_i;
      y_d = up_y_i;
    end else if (ctrl_i.pop) begin
      x_d = down_x_i;
      y_d = down_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

// File: design/mchp_cross.sv
// ----------------------------------------------------------------------------
// mchp_cross: turn test for the last chain edge
// Registers both cross product terms, then compares them: a right turn is
// (b - a) x (p - b) strictly negative.
// ----------------------------------------------------------------------------
module mchp_cross #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic signed [COORD_WIDTH-1:0] a_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_y_i,
  input  logic signed [COORD_WIDTH-1:0] b_x_i,
  input  logic signed [COORD_WIDTH-1:0] b_y_i,
  input  logic signed [COORD_WIDTH-1:0] p_x_i,
  input  logic signed [COORD_WIDTH-1:0] p_y_i,
  output logic                          right_turn_o
);

  localparam int DiffW = COORD_WIDTH + 1;
  localparam int ProdW = 2 * DiffW;

  logic signed [DiffW-1:0] d1x, d1y, d2x, d2y;
  logic signed [ProdW-1:0] lhs_q, lhs_d;
  logic signed [ProdW-1:0] rhs_q, rhs_d;

  // edge vectors, exact at one extra bit
  always_comb begin
    d1x = DiffW'(b_x_i) - DiffW'(a_x_i);
    d1y = DiffW'(b_y_i) - DiffW'(a_y_i);
    d2x = DiffW'(p_x_i) - DiffW'(b_x_i);
    d2y = DiffW'(p_y_i) - DiffW'(b_y_i);
    lhs_d = ProdW'(d1x) * ProdW'(d2y);
    rhs_d = ProdW'(d1y) * ProdW'(d2x);
  end

  always_ff @(posedge clk_i) begin
    lhs_q <= lhs_d;
    rhs_q <= rhs_d;
  end

  assign right_turn_o = lhs_q < rhs_q;

endmodule

// File: design/monotone_chain_hull_pass_unit.sv
// ----------------------------------------------------------------------------
// monotone_chain_hull_pass_unit: one monotone chain of a convex hull
// Steps: clear and unused commands go straight to the finish state, a read
// passes the read state, an add runs one turn test (product stage, compare)
// per popped point, plus the final test that fails while two or more points
// remain, then the push state. One item in flight: the input is ready again
// once the item leaves the finish state; the next is taken while a result
// waits in the output register. Reset empties the chain and the handshake
// state; the stack RAM is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
// The two top stack entries sit in a short chain of cells that shifts on
// push and pop; deeper entries live in RAM and refill the chain on a pop.
module monotone_chain_hull_pass_unit #(
  parameter int STACK_DEPTH = 1024,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             cmd_i,
  input  logic signed [COORD_WIDTH-1:0]          point_x_i,
  input  logic signed [COORD_WIDTH-1:0]          point_y_i,
  input  logic [$clog2(STACK_DEPTH)-1:0]         read_index_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [$clog2(STACK_DEPTH+1)-1:0]       hull_count_o,
  output logic [$clog2(STACK_DEPTH)-1:0]         popped_o,
  output logic signed [COORD_WIDTH-1:0]          read_x_o,
  output logic signed [COORD_WIDTH-1:0]          read_y_o,
  output logic                                   read_valid_o,
  output logic                                   overflow_o
);

  localparam int IdxW = $clog2(STACK_DEPTH);
  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam int W    = COORD_WIDTH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_PUSH = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [CntW-1:0]       top_q, top_d;
  logic [IdxW-1:0]       pop_cnt_q, pop_cnt_d;
  logic                  rvalid_q, rvalid_d;
  logic                  ovf_q, ovf_d;
  logic signed [W-1:0]   px_q, py_q;
  logic signed [W-1:0]   rx_q, rx_d, ry_q, ry_d;
  // held read index for the range check
  logic [IdxW-1:0]       read_index_q;

  logic                  out_valid_q;
  logic [CntW-1:0]       out_cnt_q;
  logic [IdxW-1:0]       out_pop_q;
  logic signed [W-1:0]   out_x_q, out_y_q;
  logic                  out_rv_q, out_ovf_q;

  logic                  in_xfer;
  logic                  out_free;
  logic                  right_turn;
  logic                  stack_full;
  logic                  ram_we;
  logic [IdxW-1:0]       ram_raddr;
  logic [2*W-1:0]        ram_rdata;
  logic [CntW-1:0]       below3;
  mchp_pkg::stack_ctrl_t ctrl;

  logic signed [W-1:0]   c0_x, c0_y, c1_x, c1_y;
  logic signed [W-1:0]   ram_x, ram_y;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign stack_full = (top_q == CntW'(STACK_DEPTH));
  assign below3     = top_q - CntW'(3);
  assign ram_x      = ram_rdata[2*W-1:W];
  assign ram_y      = ram_rdata[W-1:0];

  // RAM read address: requested entry on a read, refill entry during the test
  assign ram_raddr = (state_q == ST_IDLE) ? read_index_i : below3[IdxW-1:0];

  // sequencer
  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    pop_cnt_d = pop_cnt_q;
    rvalid_d  = rvalid_q;
    ovf_d     = ovf_q;
    rx_d      = rx_q;
    ry_d      = ry_q;
    ctrl      = '0;
    ram_we    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          pop_cnt_d = '0;
          rvalid_d  = 1'b0;
          ovf_d     = 1'b0;
          rx_d      = '0;
          ry_d      = '0;
          case (cmd_i)
            mchp_pkg::CMD_CLEAR: begin
              top_d   = '0;
              state_d = ST_FIN;
            end
            mchp_pkg::CMD_ADD: begin
              state_d = (top_q >= CntW'(2)) ? ST_MUL : ST_PUSH;
            end
            mchp_pkg::CMD_READ: begin
              state_d = ST_RD;
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_MUL: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (right_turn) begin
          ctrl.pop  = 1'b1;
          top_d     = top_q - CntW'(1);
          pop_cnt_d = pop_cnt_q + IdxW'(1);
          state_d   = (top_q >= CntW'(3)) ? ST_MUL : ST_PUSH;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (stack_full) begin
          ovf_d = 1'b1;
        end else begin
          ctrl.push = 1'b1;
          ram_we    = 1'b1;
          top_d     = top_q + CntW'(1);
        end
        state_d = ST_FIN;
      end
      ST_RD: begin
        if (CntW'(read_index_q) < top_q) begin
          rvalid_d = 1'b1;
          rx_d     = ram_x;
          ry_d     = ram_y;
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      top_q     <= '0;
      pop_cnt_q <= '0;
      rvalid_q  <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      top_q     <= top_d;
      pop_cnt_q <= pop_cnt_d;
      rvalid_q  <= rvalid_d;
      ovf_q     <= ovf_d;
    end
  end

  // item payload and read data
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q         <= point_x_i;
      py_q         <= point_y_i;
      read_index_q <= read_index_i;
    end
    rx_q <= rx_d;
    ry_q <= ry_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_cnt_q <= top_q;
      out_pop_q <= pop_cnt_q;
      out_x_q   <= rx_q;
      out_y_q   <= ry_q;
      out_rv_q  <= rvalid_q;
      out_ovf_q <= ovf_q;
    end
  end

  // stack RAM, one word per entry
  mchp_ram #(
    .WIDTH (2 * W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (top_q[IdxW-1:0]),
    .wdata_i ({px_q, py_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // top-of-stack cells: cell 0 is the top entry, cell 1 the one below
  mchp_cell #(.COORD_WIDTH(W)) u_cell0 (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .up_x_i   (px_q),
    .up_y_i   (py_q),
    .down_x_i (c1_x),
    .down_y_i (c1_y),
    .x_o      (c0_x),
    .y_o      (c0_y)
  );

  mchp_cell #(.COORD_WIDTH(W)) u_cell1 (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .up_x_i   (c0_x),
    .up_y_i   (c0_y),
    .down_x_i (ram_x),
    .down_y_i (ram_y),
    .x_o      (c1_x),
    .y_o      (c1_y)
  );

  // turn test on the two top cells and the new point
  mchp_cross #(.COORD_WIDTH(W)) u_cross (
    .clk_i        (clk_i),
    .a_x_i        (c1_x),
    .a_y_i        (c1_y),
    .b_x_i        (c0_x),
    .b_y_i        (c0_y),
    .p_x_i        (px_q),
    .p_y_i        (py_q),
    .right_turn_o (right_turn)
  );

  assign out_valid_o  = out_valid_q;
  assign hull_count_o = out_cnt_q;
  assign popped_o     = out_pop_q;
  assign read_x_o     = out_x_q;
  assign read_y_o     = out_y_q;
  assign read_valid_o = out_rv_q;
  assign overflow_o   = out_ovf_q;

endmodule

// File: design/mchp_checker.sv
// ----------------------------------------------------------------------------
// mchp_checker: port-level checks for the hull pass unit
// Watches the result channel for holding and field consistency.
// ----------------------------------------------------------------------------
module mchp_checker #(
  parameter int STACK_DEPTH = 1024,
  parameter int COORD_WIDTH = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [1:0]                       cmd_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [$clog2(STACK_DEPTH+1)-1:0] hull_count_o,
  input logic [$clog2(STACK_DEPTH)-1:0]   popped_o,
  input logic signed [COORD_WIDTH-1:0]    read_x_o,
  input logic signed [COORD_WIDTH-1:0]    read_y_o,
  input logic                             read_valid_o,
  input logic                             overflow_o
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hull_count_o)
      && $stable(popped_o) && $stable(read_valid_o))
    else $error("result changed while stalled");

  // a clear command with no result waiting leaves an empty chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == mchp_pkg::CMD_CLEAR && !out_valid_o
      |-> ##2 out_valid_o && hull_count_o == '0)
    else $error("clear did not empty the chain");

  // a hit read needs a nonempty chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_valid_o |-> hull_count_o != '0 && popped_o == '0
      && !overflow_o)
    else $error("read hit on an empty chain");

  // overflow only with a full stack and no pops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> hull_count_o == CntW'(STACK_DEPTH)
      && popped_o == '0 && !read_valid_o)
    else $error("overflow without a full stack");

  // a miss returns zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !read_valid_o |-> read_x_o == '0 && read_y_o == '0)
    else $error("coordinates set without a read hit");

endmodule

bind monotone_chain_hull_pass_unit mchp_checker #(
  .STACK_DEPTH (STACK_DEPTH),
  .COORD_WIDTH (COORD_WIDTH)
) u_mchp_checker (.*);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking regression for monotone_chain_hull_pass_unit
// Streams clear, add, read and unused commands through the valid/ready
// channels with random idle gaps on both sides. A scoreboard keeps its own
// copy of the hull stack, predicts every result with exact integer cross
// products and compares each output transfer field by field. The stimulus
// covers coordinate extremes, collinear and duplicate points, lower and
// upper chains, a completely filled stack with an overflow, and one add
// that pops almost the whole stack.
// ----------------------------------------------------------------------------

// one predicted or observed result transfer
typedef struct packed {
  logic [10:0]        hull_count;
  logic [9:0]         popped;
  logic signed [15:0] read_x;
  logic signed [15:0] read_y;
  logic               read_valid;
  logic               overflow;
} hull_result_t;

class hull_scoreboard;
  localparam int DEPTH = 1024;

  logic signed [15:0] stack_x [DEPTH];
  logic signed [15:0] stack_y [DEPTH];
  int unsigned        hull_size;
  hull_result_t       pending[$];

  int errors;
  int results_seen;
  int adds, pops_total, longest_pop, overflows;
  int read_hits, read_misses, clears, unused_cmds, tallest;

  function new();
    hull_size = 0;
  endfunction

  // advance the stack model by one input transfer and queue the result
  function void take_item(logic [1:0] cmd, logic signed [15:0] px,
                          logic signed [15:0] py, logic [9:0] idx);
    hull_result_t r;
    longint d1x, d1y, d2x, d2y;
    r = '0;
    case (cmd)
      mchp_pkg::CMD_CLEAR: begin
        hull_size = 0;
        clears++;
      end
      mchp_pkg::CMD_ADD: begin
        adds++;
        // pop while the last edge and the edge to the new point turn right
        while (hull_size >= 2) begin
          d1x = longint'(stack_x[hull_size-1]) - longint'(stack_x[hull_size-2]);
          d1y = longint'(stack_y[hull_size-1]) - longint'(stack_y[hull_size-2]);
          d2x = longint'(px) - longint'(stack_x[hull_size-1]);
          d2y = longint'(py) - longint'(stack_y[hull_size-1]);
          if (d1x * d2y - d1y * d2x >= 0) break;
          hull_size--;
          r.popped++;
        end
        if (hull_size < DEPTH) begin
          stack_x[hull_size] = px;
          stack_y[hull_size] = py;
          hull_size++;
        end else begin
          r.overflow = 1'b1;
          overflows++;
        end
        pops_total += int'(r.popped);
        if (int'(r.popped) > longest_pop) longest_pop = int'(r.popped);
        if (hull_size > tallest) tallest = hull_size;
      end
      mchp_pkg::CMD_READ: begin
        if (idx < hull_size) begin
          r.read_x     = stack_x[idx];
          r.read_y     = stack_y[idx];
          r.read_valid = 1'b1;
          read_hits++;
        end else begin
          read_misses++;
        end
      end
      default: unused_cmds++;
    endcase
    r.hull_count = 11'(hull_size);
    pending.push_back(r);
  endfunction

  // compare one output transfer with the oldest prediction
  function void check_result(hull_result_t got);
    hull_result_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: count %0d popped %0d", got.hull_count, got.popped);
      return;
    end
    want = pending.pop_front();
    results_seen++;
    if (got.hull_count !== want.hull_count || got.popped !== want.popped ||
        got.read_x !== want.read_x || got.read_y !== want.read_y ||
        got.read_valid !== want.read_valid || got.overflow !== want.overflow) begin
      errors++;
      if (errors <= 10) begin
        $display("result %0d mismatch (expected / actual):", results_seen);
        $display("  count %0d/%0d popped %0d/%0d x %0d/%0d y %0d/%0d vld %0b/%0b ovf %0b/%0b",
                 want.hull_count, got.hull_count, want.popped, got.popped,
                 want.read_x, got.read_x, want.read_y, got.read_y,
                 want.read_valid, got.read_valid, want.overflow, got.overflow);
      end
    end
  endfunction
endclass

module testbench;
  localparam int STACK_DEPTH    = 1024;
  localparam int COORD_WIDTH    = 16;
  localparam int RANDOM_ITEMS   = 100;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 20;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [1:0]        cmd_i        = mchp_pkg::CMD_CLEAR;
  logic signed [15:0] point_x_i   = '0;
  logic signed [15:0] point_y_i   = '0;
  logic [9:0]        read_index_i = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [10:0]       hull_count_o;
  logic [9:0]        popped_o;
  logic signed [15:0] read_x_o;
  logic signed [15:0] read_y_o;
  logic              read_valid_o;
  logic              overflow_o;

  hull_scoreboard sb;
  bit             calm = 1'b0;  // when set, neither side idles

  monotone_chain_hull_pass_unit #(
    .STACK_DEPTH(STACK_DEPTH),
    .COORD_WIDTH(COORD_WIDTH)
  ) dut (.*);

  // clock, period 2
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // present one item and hold it until the input transfer
  task automatic send(logic [1:0] cmd, logic signed [15:0] px,
                      logic signed [15:0] py, logic [9:0] idx);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    point_x_i    <= px;
    point_y_i    <= py;
    read_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_item(cmd, px, py, idx);
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stalls, check every output transfer
  initial begin
    int stall;
    hull_result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.hull_count = hull_count_o;
      got.popped     = popped_o;
      got.read_x     = read_x_o;
      got.read_y     = read_y_o;
      got.read_valid = read_valid_o;
      got.overflow   = overflow_o;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet);
        $display("monotone_chain_hull_pass_unit regression: fail");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int sent, n, k, mode;
    int unsigned keys[$];
    logic [31:0] key;
    logic signed [15:0] cx, cy, base_x, base_y;
    bit boxed;

    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty chain, coordinate extremes, right turns, reads
    send(CMD_UNUSED, -1, -1, 10'h3FF);
    send(mchp_pkg::CMD_READ, 0, 0, 0);
    send(mchp_pkg::CMD_ADD, -32768, -32768, 0);
    send(mchp_pkg::CMD_ADD, -32768, 32767, 10'h3FF);
    send(mchp_pkg::CMD_ADD, 0, 32767, 0);
    send(mchp_pkg::CMD_ADD, 32767, -32768, 0);
    send(mchp_pkg::CMD_ADD, 32767, 32767, 0);
    for (k = 0; k < 4; k++) send(mchp_pkg::CMD_READ, 0, 0, 10'(k));
    send(mchp_pkg::CMD_READ, -1, -1, 10'h3FF);
    send(CMD_UNUSED, 0, 0, 0);
    send(mchp_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 10'($urandom));
    send(mchp_pkg::CMD_READ, 0, 0, 0);
    // collinear and duplicate points are kept
    send(mchp_pkg::CMD_ADD, 0, 0, 0);
    send(mchp_pkg::CMD_ADD, 1, 1, 0);
    send(mchp_pkg::CMD_ADD, 2, 2, 0);
    send(mchp_pkg::CMD_ADD, 2, 2, 0);
    send(mchp_pkg::CMD_ADD, 3, -5, 0);
    send(mchp_pkg::CMD_READ, 0, 0, 1);
    send(mchp_pkg::CMD_CLEAR, 0, 0, 0);

    // fill the whole stack along a horizontal line, then overflow it,
    // then pop everything but the first point with one add
    drain_results();
    base_x = 16'($urandom_range(0, 64510) - 32768);
    base_y = 16'($urandom_range(1, 65535) - 32768);
    send(mchp_pkg::CMD_CLEAR, 0, 0, 0);
    for (k = 0; k < STACK_DEPTH; k++)
      send(mchp_pkg::CMD_ADD, 16'(base_x + k), base_y, 10'($urandom));
    send(mchp_pkg::CMD_ADD, 16'(base_x + STACK_DEPTH), base_y, 0);
    send(mchp_pkg::CMD_READ, 0, 0, 10'h3FF);
    send(mchp_pkg::CMD_ADD, 16'(base_x + STACK_DEPTH + 1), 16'(base_y - 1), 0);
    send(mchp_pkg::CMD_READ, 0, 0, 1);

    // random part: mostly sorted point runs, some noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 19) == 0) drain_results();
      mode = $urandom_range(0, 9);
      if (mode < 8) begin
        // sorted run, lower or upper chain, full range or a tiny box
        if ($urandom_range(0, 7) != 0) begin
          send(mchp_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 10'($urandom));
          sent++;
        end
        boxed = 1'($urandom_range(0, 1));
        cx = 16'($urandom_range(0, 65526) - 32763);
        cy = 16'($urandom_range(0, 65526) - 32763);
        n = $urandom_range(2, 40);
        keys.delete();
        for (k = 0; k < n; k++) begin
          if (boxed) begin
            key[31:16] = 16'(cx + $urandom_range(0, 8) - 4) ^ 16'h8000;
            key[15:0]  = 16'(cy + $urandom_range(0, 8) - 4) ^ 16'h8000;
          end else begin
            key = $urandom;
          end
          keys.push_back(key);
        end
        keys.sort();
        if ($urandom_range(0, 2) == 0) keys.reverse();
        foreach (keys[k]) begin
          key = keys[k];
          send(mchp_pkg::CMD_ADD, key[31:16] ^ 16'h8000, key[15:0] ^ 16'h8000,
               10'($urandom));
          sent++;
          if ($urandom_range(0, 4) == 0) begin
            if ($urandom_range(0, 3) == 0)
              send(mchp_pkg::CMD_READ, 16'($urandom), 16'($urandom), 10'($urandom));
            else
              send(mchp_pkg::CMD_READ, 16'($urandom), 16'($urandom),
                   10'($urandom_range(0, sb.hull_size)));
            sent++;
          end
        end
      end else begin
        // noise: any command, unsorted points, any index
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          send(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 10'($urandom));
          sent++;
        end
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d adds (%0d pops, longest pop run %0d, %0d overflows), %0d clears,",
             sb.adds, sb.pops_total, sb.longest_pop, sb.overflows, sb.clears);
    $display("  %0d reads in range, %0d out of range, %0d unused commands, chain up to %0d",
             sb.read_hits, sb.read_misses, sb.unused_cmds, sb.tallest);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("monotone_chain_hull_pass_unit regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("monotone_chain_hull_pass_unit regression: fail");
    end
    $finish;
  end

endmodule
